[design/cdfe_pkg.sv]
// Shared types, constants and helper functions for the clock date field editor.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package cdfe_pkg;

    // Time fields are kept as 7-bit values; each result port shows the low bits.
    localparam int FIELD_W    = 7;
    localparam int NUM_FIELDS = 6;

    // Number of millisecond ticks between two toggles of the blink phase.
    localparam int BLINK_TICKS = 500;
    localparam int TICK_W      = $clog2(BLINK_TICKS);

    typedef logic [FIELD_W-1:0] tval_t;
    typedef tval_t [NUM_FIELDS-1:0] tfields_t;
    typedef logic [2:0] fsel_t;

    localparam fsel_t FLD_YEAR   = 3'd0;
    localparam fsel_t FLD_MONTH  = 3'd1;
    localparam fsel_t FLD_DAY    = 3'd2;
    localparam fsel_t FLD_HOUR   = 3'd3;
    localparam fsel_t FLD_MINUTE = 3'd4;
    localparam fsel_t FLD_SECOND = 3'd5;

    typedef enum logic [2:0] {
        OP_MODE = 3'd0,
        OP_NEXT = 3'd1,
        OP_INC  = 3'd2,
        OP_DEC  = 3'd3,
        OP_TICK = 3'd4,
        OP_LOAD = 3'd5
    } op_t;

    // One accepted request as it sits in the input register.
    typedef struct packed {
        op_t      op;
        tfields_t load;
    } cmd_t;

    // One result as it sits in the output register.
    typedef struct packed {
        tfields_t fields;
        fsel_t    field;
        logic     editing;
        logic     blank;
        logic     commit;
    } result_t;

    // Length of a month; zero for a month code that names no month.
    function automatic logic [4:0] month_days(input tval_t month, input logic [1:0] year_lo);
        logic [4:0] len;
        begin
            unique case (month)
                7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
                7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
                7'd2:    len = (year_lo == 2'b00) ? 5'd29 : 5'd28;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

[design/clock_date_field_editor_unit.sv]
// Top level of the clock date field editor: input register, editor core and
// result register with valid/ready handshakes. Uses cdfe_pkg and cdfe_core.
`timescale 1ns / 1ps
//
//  Channel   Handshake             Payload
//  --------  --------------------  ---------------------------------------------
//  request   cmd_valid/cmd_ready   operation, load_year .. load_second
//  result    res_valid/res_ready   year .. second, field, editing, blank, commit
//
// Every request yields exactly one result. A request is first held in the
// input register. At the edge that executes it, the core updates its state
// and loads the result register in the same edge. The result thus goes
// through the input register and the result register, and it stays there
// until it is taken. One request per cycle is sustained while res_ready stays
// high; the only loop is the state feedback through the core.
// Reset puts the clock at year 0, month 1, day 1, 00:00:00, out of edit mode.
// When res_ready is low, the result stays put and the request in the input
// register waits; cmd_ready then drops only once the input register is full.

module clock_date_field_editor_unit
    import cdfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [2:0] operation,
    input  logic [6:0] load_year,
    input  logic [3:0] load_month,
    input  logic [4:0] load_day,
    input  logic [4:0] load_hour,
    input  logic [5:0] load_minute,
    input  logic [5:0] load_second,

    output logic       res_valid,
    input  logic       res_ready,
    output logic [6:0] year,
    output logic [3:0] month,
    output logic [4:0] day,
    output logic [4:0] hour,
    output logic [5:0] minute,
    output logic [5:0] second,
    output logic [2:0] field,
    output logic       editing,
    output logic       blank,
    output logic       commit
);

    cmd_t    cmd_reg, cmd_next;
    logic    cmd_valid_reg;
    result_t res_reg;
    result_t core_result;
    logic    res_valid_reg;
    logic    advance;
    logic    exec;
    logic    cmd_fire;

    // The pipeline moves whenever the result register is empty or being drained.
    assign advance   = !res_valid_reg || res_ready;
    assign exec      = cmd_valid_reg && advance;
    assign cmd_ready = !cmd_valid_reg || advance;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Load values are widened to the common field width of the state store.
    always_comb
    begin
        cmd_next.op               = op_t'(operation);
        cmd_next.load[FLD_YEAR]   = load_year;
        cmd_next.load[FLD_MONTH]  = {3'b000, load_month};
        cmd_next.load[FLD_DAY]    = {2'b00, load_day};
        cmd_next.load[FLD_HOUR]   = {2'b00, load_hour};
        cmd_next.load[FLD_MINUTE] = {1'b0, load_minute};
        cmd_next.load[FLD_SECOND] = {1'b0, load_second};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= cmd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg <= cmd_next;
        end
        if (exec)
        begin
            res_reg <= core_result;
        end
    end

    cdfe_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .cmd    (cmd_reg),
        .result (core_result)
    );

    // Each port shows the low bits of its 7-bit field.
    assign res_valid = res_valid_reg;
    assign year      = res_reg.fields[FLD_YEAR];
    assign month     = res_reg.fields[FLD_MONTH][3:0];
    assign day       = res_reg.fields[FLD_DAY][4:0];
    assign hour      = res_reg.fields[FLD_HOUR][4:0];
    assign minute    = res_reg.fields[FLD_MINUTE][5:0];
    assign second    = res_reg.fields[FLD_SECOND][5:0];
    assign field     = res_reg.field;
    assign editing   = res_reg.editing;
    assign blank     = res_reg.blank;
    assign commit    = res_reg.commit;

    // A commit is only reported by the result that leaves edit mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.commit |-> !res_reg.editing)
        else $error("commit reported while still in edit mode");

    // The selected field never leaves the six valid codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.field <= FLD_SECOND))
        else $error("selected field out of range");

    // A request held in the input register while stalled is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !advance |=> cmd_valid_reg && $stable(cmd_reg))
        else $error("stalled request lost or changed");

    // A result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(res_reg))
        else $error("pending result changed before it was taken");

endmodule

[design/cdfe_field_math.sv]
// Increment or decrement of the selected time field, followed by the wrap rules
// for every field and a clamp to the 7-bit storage range. Uses cdfe_pkg.
`timescale 1ns / 1ps

module cdfe_field_math
    import cdfe_pkg::*;
(
    input  tfields_t fields_in,
    input  fsel_t    sel,
    input  logic     down,
    output tfields_t fields_out
);

    logic signed [8:0] w [NUM_FIELDS];
    logic signed [8:0] delta;
    logic [4:0]        len;
    logic signed [8:0] len_s;

    always_comb
    begin
        delta = down ? -9'sd1 : 9'sd1;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            w[i] = $signed({2'b00, fields_in[i]}) + ((sel == 3'(i)) ? delta : 9'sd0);
        end

        // Year and month settle first since the day rule depends on both.
        if (!down)
        begin
            if (w[FLD_YEAR] > 9'sd99)
            begin
                w[FLD_YEAR] = 9'sd0;
            end
            if (w[FLD_MONTH] > 9'sd12)
            begin
                w[FLD_MONTH] = 9'sd1;
            end
        end
        else
        begin
            if (w[FLD_YEAR] < 9'sd0)
            begin
                w[FLD_YEAR] = 9'sd99;
            end
            if (w[FLD_MONTH] < 9'sd1)
            begin
                w[FLD_MONTH] = 9'sd12;
            end
        end

        // Both values are non-negative and below 128 here.
        len   = month_days(w[FLD_MONTH][6:0], w[FLD_YEAR][1:0]);
        len_s = $signed({4'b0000, len});

        if (!down)
        begin
            if (len != 5'd0 && w[FLD_DAY] > len_s)
            begin
                w[FLD_DAY] = 9'sd1;
            end
            if (w[FLD_HOUR] > 9'sd23)
            begin
                w[FLD_HOUR] = 9'sd0;
            end
            if (w[FLD_MINUTE] > 9'sd59)
            begin
                w[FLD_MINUTE] = 9'sd0;
            end
            if (w[FLD_SECOND] > 9'sd59)
            begin
                w[FLD_SECOND] = 9'sd0;
            end
        end
        else
        begin
            if (len != 5'd0)
            begin
                if (w[FLD_DAY] < 9'sd1)
                begin
                    w[FLD_DAY] = len_s;
                end
                if (w[FLD_DAY] > len_s)
                begin
                    w[FLD_DAY] = 9'sd1;
                end
            end
            if (w[FLD_HOUR] < 9'sd0)
            begin
                w[FLD_HOUR] = 9'sd23;
            end
            if (w[FLD_MINUTE] < 9'sd0)
            begin
                w[FLD_MINUTE] = 9'sd59;
            end
            if (w[FLD_SECOND] < 9'sd0)
            begin
                w[FLD_SECOND] = 9'sd59;
            end
        end

        // A day with no month rule can leave the storage range either way.
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (w[i] < 9'sd0)
            begin
                fields_out[i] = '0;
            end
            else if (w[i] > 9'sd127)
            begin
                fields_out[i] = '1;
            end
            else
            begin
                fields_out[i] = w[i][6:0];
            end
        end
    end

endmodule

[design/cdfe_core.sv]
// Editor state registers and the per-request update: mode, field select, step,
// blink tick counter and load. Uses cdfe_pkg and cdfe_field_math.
`timescale 1ns / 1ps

module cdfe_core
    import cdfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    exec,
    input  cmd_t    cmd,
    output result_t result
);

    tfields_t          fields_reg, fields_next;
    fsel_t             sel_reg, sel_next;
    logic              edit_reg, edit_next;
    logic              blink_reg, blink_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              commit;
    tfields_t          stepped;

    cdfe_field_math u_math (
        .fields_in  (fields_reg),
        .sel        (sel_reg),
        .down       (cmd.op == OP_DEC),
        .fields_out (stepped)
    );

    always_comb
    begin
        fields_next = fields_reg;
        sel_next    = sel_reg;
        edit_next   = edit_reg;
        blink_next  = blink_reg;
        tick_next   = tick_reg;
        commit      = 1'b0;
        unique case (cmd.op)
            OP_MODE:
            begin
                edit_next = !edit_reg;
                commit    = edit_reg;
            end
            OP_NEXT:
            begin
                if (edit_reg)
                begin
                    sel_next = (sel_reg == FLD_SECOND) ? FLD_YEAR : sel_reg + 3'd1;
                end
            end
            OP_INC, OP_DEC:
            begin
                if (edit_reg)
                begin
                    fields_next = stepped;
                end
            end
            OP_TICK:
            begin
                if (tick_reg == TICK_W'(BLINK_TICKS - 1))
                begin
                    tick_next  = '0;
                    blink_next = !blink_reg;
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            OP_LOAD:
            begin
                if (!edit_reg)
                begin
                    fields_next = cmd.load;
                end
            end
            default:
            begin
            end
        endcase

        result.fields  = fields_next;
        result.field   = sel_next;
        result.editing = edit_next;
        result.blank   = edit_next & blink_next;
        result.commit  = commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg             <= '0;
            fields_reg[FLD_MONTH]  <= 7'd1;
            fields_reg[FLD_DAY]    <= 7'd1;
            sel_reg                <= FLD_YEAR;
            edit_reg               <= 1'b0;
            blink_reg              <= 1'b0;
            tick_reg               <= '0;
        end
        else if (exec)
        begin
            fields_reg <= fields_next;
            sel_reg    <= sel_next;
            edit_reg   <= edit_next;
            blink_reg  <= blink_next;
            tick_reg   <= tick_next;
        end
    end

endmodule

[sim/clock_readout_checker.sv]
// Checker for the clock date field editor: it watches both channels, keeps its own copy of the clock state,
// predicts the readout for every accepted request and compares it with what comes out of the block.
// Depends on cdfe_pkg for the operation codes and field indexes.
`timescale 1ns / 1ps

module clock_readout_checker
    import cdfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cmd_valid,
    input  logic       cmd_ready,
    input  logic [2:0] operation,
    input  logic [6:0] load_year,
    input  logic [3:0] load_month,
    input  logic [4:0] load_day,
    input  logic [4:0] load_hour,
    input  logic [5:0] load_minute,
    input  logic [5:0] load_second,

    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [6:0] year,
    input  logic [3:0] month,
    input  logic [4:0] day,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [5:0] second,
    input  logic [2:0] field,
    input  logic       editing,
    input  logic       blank,
    input  logic       commit,

    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] field;
        logic       editing;
        logic       blank;
        logic       commit;
    } readout_t;

    // Predicted clock state. Time fields are held as signed integers so that a
    // decrement below zero can be seen before it wraps.
    int       clk_fields [NUM_FIELDS];
    fsel_t    cur_field;
    logic     in_edit;
    logic     blink_on;
    int       ms_count;
    int       err_count;
    readout_t expected_readouts [$];

    assign mismatches = err_count;

    function automatic int days_in_month(input int mon, input int yr);
        case (mon)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return (yr % 4 == 0) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic string show(input readout_t r);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d field=%0d editing=%0b blank=%0b commit=%0b",
                         r.year, r.month, r.day, r.hour, r.minute, r.second,
                         r.field, r.editing, r.blank, r.commit);
    endfunction

    // Step the selected field by one and wrap every field back into range.
    // A month with no length (zero on the way up, above twelve on the way down) leaves the day alone.
    task automatic nudge_selected_field(input bit up);
        int len;
        if (up) begin
            clk_fields[cur_field] += 1;
            if (clk_fields[FLD_YEAR] > 99) clk_fields[FLD_YEAR] = 0;
            if (clk_fields[FLD_MONTH] > 12) clk_fields[FLD_MONTH] = 1;
            len = days_in_month(clk_fields[FLD_MONTH], clk_fields[FLD_YEAR]);
            if (len != 0 && clk_fields[FLD_DAY] > len) clk_fields[FLD_DAY] = 1;
            if (clk_fields[FLD_HOUR] > 23) clk_fields[FLD_HOUR] = 0;
            if (clk_fields[FLD_MINUTE] > 59) clk_fields[FLD_MINUTE] = 0;
            if (clk_fields[FLD_SECOND] > 59) clk_fields[FLD_SECOND] = 0;
        end else begin
            clk_fields[cur_field] -= 1;
            if (clk_fields[FLD_YEAR] < 0) clk_fields[FLD_YEAR] = 99;
            if (clk_fields[FLD_MONTH] < 1) clk_fields[FLD_MONTH] = 12;
            len = days_in_month(clk_fields[FLD_MONTH], clk_fields[FLD_YEAR]);
            if (len != 0) begin
                if (clk_fields[FLD_DAY] < 1) clk_fields[FLD_DAY] = len;
                if (clk_fields[FLD_DAY] > len) clk_fields[FLD_DAY] = 1;
            end
            if (clk_fields[FLD_HOUR] < 0) clk_fields[FLD_HOUR] = 23;
            if (clk_fields[FLD_MINUTE] < 0) clk_fields[FLD_MINUTE] = 59;
            if (clk_fields[FLD_SECOND] < 0) clk_fields[FLD_SECOND] = 59;
        end
        // An unwrapped day can keep climbing; the storage holds it at 0..127.
        foreach (clk_fields[i]) begin
            if (clk_fields[i] < 0) clk_fields[i] = 0;
            if (clk_fields[i] > 127) clk_fields[i] = 127;
        end
    endtask

    task automatic apply_request(output readout_t r);
        logic commit_now;
        commit_now = 1'b0;
        case (operation)
            OP_MODE: begin
                if (in_edit) begin
                    in_edit    = 1'b0;
                    commit_now = 1'b1;
                end else begin
                    in_edit = 1'b1;
                end
            end
            OP_NEXT: if (in_edit) cur_field = (cur_field == FLD_SECOND) ? FLD_YEAR : cur_field + 3'd1;
            OP_INC:  if (in_edit) nudge_selected_field(1'b1);
            OP_DEC:  if (in_edit) nudge_selected_field(1'b0);
            OP_TICK: begin
                ms_count++;
                if (ms_count >= BLINK_TICKS) begin
                    ms_count = 0;
                    blink_on = !blink_on;
                end
            end
            OP_LOAD: begin
                if (!in_edit) begin
                    clk_fields[FLD_YEAR]   = load_year;
                    clk_fields[FLD_MONTH]  = load_month;
                    clk_fields[FLD_DAY]    = load_day;
                    clk_fields[FLD_HOUR]   = load_hour;
                    clk_fields[FLD_MINUTE] = load_minute;
                    clk_fields[FLD_SECOND] = load_second;
                end
            end
            default: ;
        endcase
        r.year    = 7'(clk_fields[FLD_YEAR]);
        r.month   = 4'(clk_fields[FLD_MONTH]);
        r.day     = 5'(clk_fields[FLD_DAY]);
        r.hour    = 5'(clk_fields[FLD_HOUR]);
        r.minute  = 6'(clk_fields[FLD_MINUTE]);
        r.second  = 6'(clk_fields[FLD_SECOND]);
        r.field   = cur_field;
        r.editing = in_edit;
        r.blank   = in_edit && blink_on;
        r.commit  = commit_now;
    endtask

    always @(posedge clk or negedge rst_n) begin
        readout_t got;
        readout_t want;
        if (!rst_n) begin
            clk_fields[FLD_YEAR]   = 0;
            clk_fields[FLD_MONTH]  = 1;
            clk_fields[FLD_DAY]    = 1;
            clk_fields[FLD_HOUR]   = 0;
            clk_fields[FLD_MINUTE] = 0;
            clk_fields[FLD_SECOND] = 0;
            cur_field = FLD_YEAR;
            in_edit   = 1'b0;
            blink_on  = 1'b0;
            ms_count  = 0;
            err_count = 0;
            expected_readouts.delete();
            outstanding <= 0;
        end else begin
            if (res_valid && res_ready) begin
                got = {year, month, day, hour, minute, second, field, editing, blank, commit};
                if (expected_readouts.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: readout with no request pending: %s", $time, show(got));
                end else begin
                    want = expected_readouts.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: readout mismatch\n  expected %s\n  actual   %s",
                                     $time, show(want), show(got));
                    end
                end
            end
            if (cmd_valid && cmd_ready) begin
                apply_request(want);
                expected_readouts.push_back(want);
            end
            outstanding <= expected_readouts.size();
        end
    end

endmodule

[sim/tb.sv]
// Top of the clock date field editor testbench: clock, reset, request stimulus and the verdict.
// Depends on cdfe_pkg, clock_date_field_editor_unit and clock_readout_checker.
`timescale 1ns / 1ps

module tb;
    import cdfe_pkg::*;

    // The two operation codes that the block leaves unused; a request with
    // either of them must leave the state alone but still yield a readout.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Number of requests that actually do something, after which stimulus stops.
    localparam int EFFECTIVE_TARGET = 1900;

    // The longest correct stretch without any handshake is a receiver stall
    // on top of a sender gap; this limit is far above it.
    localparam int QUIET_LIMIT = 1000;

    // A readout passes through the input register and the result register
    // after its request, so this tail is enough to catch a stray extra readout.
    localparam int TAIL_CYCLES = 8;

    // One reading of the real-time clock, as carried by a load request.
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } rtc_reading_t;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    logic [2:0] operation;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic       res_valid;
    logic       res_ready;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] field;
    logic       editing;
    logic       blank;
    logic       commit;

    int         mismatches;
    int         outstanding;

    // Rough picture of the editor kept only to steer the stimulus: whether a
    // mode key has put it in edit mode and which field is selected.
    bit         edit_shadow;
    fsel_t      field_shadow;
    int         effective_requests;
    int         burst_left;
    int         quiet_cycles;

    // Receiver stall pattern state.
    int         rx_left;
    int         rx_mode;
    int         hold_left;
    bit         hold_ready;

    clock_date_field_editor_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .operation   (operation),
        .load_year   (load_year),
        .load_month  (load_month),
        .load_day    (load_day),
        .load_hour   (load_hour),
        .load_minute (load_minute),
        .load_second (load_second),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .field       (field),
        .editing     (editing),
        .blank       (blank),
        .commit      (commit)
    );

    clock_readout_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .operation   (operation),
        .load_year   (load_year),
        .load_month  (load_month),
        .load_day    (load_day),
        .load_hour   (load_hour),
        .load_minute (load_minute),
        .load_second (load_second),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .field       (field),
        .editing     (editing),
        .blank       (blank),
        .commit      (commit),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver switches at random among three behaviors: always ready,
    // randomly ready three times in four, or long stalls broken by short
    // ready runs. The first mode gives stretches with no stalls at all.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_ready = !hold_ready;
                    hold_left  = hold_ready ? $urandom_range(1, 10) : $urandom_range(1, 30);
                end
                hold_left--;
                res_ready <= hold_ready;
            end
        endcase
    end

    // Watchdog: a run in which no request and no readout moves for this long
    // has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("tb NOT OK");
                    $finish;
                end
            end
        end
    end

    // Mostly a sane reading; sometimes every bit random so that out-of-range
    // values get loaded too. February shows up often to exercise leap years.
    function automatic rtc_reading_t random_reading(input bit wild);
        rtc_reading_t r;
        if (wild)
        begin
            r.year   = 7'($urandom);
            r.month  = 4'($urandom);
            r.day    = 5'($urandom);
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
            r.second = 6'($urandom);
        end
        else
        begin
            r.year   = 7'($urandom_range(0, 99));
            r.month  = ($urandom_range(0, 3) == 0) ? 4'd2 : 4'($urandom_range(1, 12));
            r.day    = 5'($urandom_range(1, 31));
            r.hour   = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
            r.second = 6'($urandom_range(0, 59));
        end
        return r;
    endfunction

    // Present one request and hold it until it is accepted. Requests go out
    // in bursts; between bursts valid may drop for a random gap, and a gap of
    // zero lets two bursts run together.
    task automatic issue(input logic [2:0] op, input rtc_reading_t rd);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        cmd_valid   <= 1'b1;
        operation   <= op;
        load_year   <= rd.year;
        load_month  <= rd.month;
        load_day    <= rd.day;
        load_hour   <= rd.hour;
        load_minute <= rd.minute;
        load_second <= rd.second;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);

        // Requests that the editor merely ignores do not count toward the target.
        if (!(op == OP_SPARE_6 || op == OP_SPARE_7 ||
              (!edit_shadow && (op == OP_NEXT || op == OP_INC || op == OP_DEC)) ||
              (edit_shadow && op == OP_LOAD)))
            effective_requests++;
        if (op == OP_MODE)
            edit_shadow = !edit_shadow;
        else if (op == OP_NEXT && edit_shadow)
            field_shadow = (field_shadow == FLD_SECOND) ? FLD_YEAR : field_shadow + 3'd1;
    endtask

    // Stop sending until the checker has seen every readout it expects.
    task automatic drain_readouts();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        burst_left = 0;
    endtask

    task automatic key(input logic [2:0] op);
        issue(op, random_reading(1'b1));
    endtask

    initial
    begin
        int n;
        int pick;
        rtc_reading_t rd;

        rst_n       <= 1'b0;
        cmd_valid   <= 1'b0;
        operation   <= OP_MODE;
        load_year   <= '0;
        load_month  <= '0;
        load_day    <= '0;
        load_hour   <= '0;
        load_minute <= '0;
        load_second <= '0;
        res_ready   <= 1'b0;
        edit_shadow = 1'b0;
        field_shadow = FLD_YEAR;
        effective_requests = 0;
        burst_left = 0;
        quiet_cycles = 0;
        rx_left = 0;
        hold_left = 0;
        hold_ready = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Next, increment and decrement do nothing outside edit mode,
        // and the two spare operation codes do nothing at all.
        key(OP_NEXT);
        key(OP_INC);
        key(OP_DEC);
        key(OP_SPARE_6);
        key(OP_SPARE_7);
        // All-zero reading: month zero has no length, so its day is not wrapped.
        issue(OP_LOAD, {7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0});
        key(OP_MODE);
        // A load while editing must be ignored.
        issue(OP_LOAD, {7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63});
        key(OP_INC);   // year 1, month still zero, day left at zero
        key(OP_DEC);   // year 0, month wraps to 12 and day zero becomes 31
        key(OP_DEC);   // year below zero wraps to 99
        key(OP_NEXT);
        key(OP_DEC);   // November: day 31 wraps to 1
        key(OP_MODE);  // leaving edit mode raises commit
        // Every load field at its all-ones value, taken unchecked.
        issue(OP_LOAD, {7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63});
        key(OP_MODE);
        key(OP_INC);   // month past 12 wraps; year, hour, minute and second are pulled back
        key(OP_MODE);
        // Leap year February 29, then move to the year and leave the leap year.
        issue(OP_LOAD, {7'd0, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59});
        key(OP_MODE);
        repeat (5) key(OP_NEXT);  // field selection wraps from second to year
        key(OP_INC);
        key(OP_MODE);

        drain_readouts();

        // Random part, built from short scenarios until enough requests that
        // actually change something have gone through.
        while (effective_requests < EFFECTIVE_TARGET)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4:
                begin
                    // Edit session: enter, random key presses, usually leave.
                    if (!edit_shadow) key(OP_MODE);
                    n = $urandom_range(3, 30);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 9))
                            0, 1:          key(OP_NEXT);
                            2, 3, 4, 5:    key(OP_INC);
                            default:       key(OP_DEC);
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0) key(OP_MODE);
                end
                5:
                begin
                    // Load a reading; once in a while while still editing.
                    if (edit_shadow && $urandom_range(0, 3) != 0) key(OP_MODE);
                    issue(OP_LOAD, random_reading($urandom_range(0, 3) == 0));
                end
                6:
                begin
                    // Run of millisecond ticks; successive runs add up to flip the blink phase.
                    n = $urandom_range(50, 400);
                    repeat (n) key(OP_TICK);
                end
                7:
                begin
                    // Noise: any operation code with any payload.
                    n = $urandom_range(1, 6);
                    repeat (n) key(3'($urandom_range(0, 7)));
                end
                8:
                begin
                    // Month zero leaves the day unwrapped, so counting it up drives it far past
                    // any month length and, from a high enough start day, into saturation at the top of its storage.
                    if (edit_shadow) key(OP_MODE);
                    rd = random_reading(1'b1);
                    rd.month = 4'd0;
                    issue(OP_LOAD, rd);
                    key(OP_MODE);
                    while (field_shadow != FLD_DAY) key(OP_NEXT);
                    n = $urandom_range(100, 110);
                    repeat (n) key(OP_INC);
                    n = $urandom_range(1, 5);
                    repeat (n) key(OP_DEC);
                    key(OP_MODE);
                end
                default:
                begin
                    drain_readouts();
                end
            endcase
        end

        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[clock_date_field_editor_unit.f]
design/cdfe_pkg.sv
design/cdfe_field_math.sv
design/cdfe_core.sv
design/clock_date_field_editor_unit.sv
sim/clock_readout_checker.sv
sim/tb.sv
